@@ hw/rtl/tst_pkg.sv @@
// Shared widths, mode codes and command/status types for the triaxial sample transform.
`default_nettype none
package tst_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int DIFF_BITS      = SAMPLE_BITS + 1;
    localparam int PROD_BITS      = 2 * DIFF_BITS;
    localparam int ACC_BITS       = 2 * DIFF_BITS;
    localparam int L1_BITS        = DIFF_BITS + 2;
    localparam int FRAC_SHIFT     = 16;
    localparam int RAD_BITS       = ACC_BITS + FRAC_SHIFT;
    localparam int ROOT_BITS      = RAD_BITS / 2;
    localparam int REM_BITS       = ROOT_BITS + 3;
    localparam int ROOT_CNT_BITS  = $clog2(ROOT_BITS + 1);
    localparam int VALUE_BITS     = 36;
    localparam int IN_TDATA_BITS  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [2:0] MODE_JERK        = 3'd0;
    localparam logic [2:0] MODE_MAGSQ       = 3'd1;
    localparam logic [2:0] MODE_MAG         = 3'd2;
    localparam logic [2:0] MODE_L1          = 3'd3;
    localparam logic [2:0] MODE_JERK_MAGSQ  = 3'd4;
    localparam logic [2:0] MODE_JERK_MAG    = 3'd5;
    localparam logic [2:0] MODE_JERK_L1     = 3'd6;
    localparam logic [2:0] MODE_MEDIAN      = 3'd7;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE        = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_SELECT = CFG_INDEX_BITS'(1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [DIFF_BITS-1:0]   diff_t;
    typedef logic signed [VALUE_BITS-1:0]  value_t;

    typedef struct packed {
        logic       accept;
        logic       mac_step;
        logic [1:0] mac_idx;
        logic       sqrt_start;
        logic       load_main;
        logic       load_last;
    } cmd_t;

    typedef struct packed {
        logic need_mac;
        logic need_sqrt;
        logic has_main;
        logic is_final;
        logic sqrt_done;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/tst_sqrt.sv @@
// Iterative floor square root, two radicand bits per cycle.
`default_nettype none
module tst_sqrt (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [tst_pkg::RAD_BITS-1:0]      radicand,
    output logic                                   done,
    output logic [tst_pkg::ROOT_BITS-1:0]          root
);

    logic                                 busy_reg;
    logic [tst_pkg::ROOT_CNT_BITS-1:0]    cnt_reg;
    logic [tst_pkg::RAD_BITS-1:0]         rad_reg;
    logic [tst_pkg::REM_BITS-1:0]         rem_reg;
    logic [tst_pkg::ROOT_BITS-1:0]        root_reg;

    logic [tst_pkg::REM_BITS-1:0]         rem_shift;
    logic [tst_pkg::REM_BITS-1:0]         trial;
    logic                                 fits;

    always_comb
    begin
        rem_shift = {rem_reg[tst_pkg::REM_BITS-3:0], rad_reg[tst_pkg::RAD_BITS-1 -: 2]};
        trial     = tst_pkg::REM_BITS'({root_reg, 2'b01});
        fits      = (rem_shift >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= tst_pkg::ROOT_CNT_BITS'(tst_pkg::ROOT_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == tst_pkg::ROOT_CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[tst_pkg::RAD_BITS-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[tst_pkg::ROOT_BITS-2:0], fits};
        end
    end

    assign done = !busy_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

@@ hw/rtl/tst_datapath.sv @@
// Datapath: config registers, sample history, shared multiplier, root unit, output register.
`default_nettype none
module tst_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tst_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [tst_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  wire logic [tst_pkg::IN_TDATA_BITS-1:0]     s_tdata,
    input  wire logic                                  s_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [tst_pkg::OUT_TDATA_BITS-1:0]         m_tdata,
    output logic                                       m_tlast,
    input  wire tst_pkg::cmd_t                         cmd,
    output tst_pkg::status_t                           status
);

    logic [2:0]                         mode_reg;
    logic [1:0]                         axis_reg;

    tst_pkg::sample_t                   prev_reg [3];
    tst_pkg::sample_t                   older_reg;
    logic [1:0]                         seen_reg;

    logic [2:0]                         kind_reg;
    logic                               need_mac_reg;
    logic                               need_sqrt_reg;
    logic                               has_main_reg;
    logic                               final_reg;
    tst_pkg::diff_t                     op_reg [3];
    tst_pkg::value_t                    simple_reg;
    logic signed [tst_pkg::PROD_BITS-1:0] prod_reg;
    logic [tst_pkg::ACC_BITS-1:0]       acc_reg;

    logic                               m_tvalid_reg;
    tst_pkg::value_t                    m_value_reg;
    logic                               m_last_reg;

    tst_pkg::sample_t                   s_in [3];
    tst_pkg::diff_t                     d_in [3];
    logic [1:0]                         ax;
    tst_pkg::sample_t                   cur_ax;
    tst_pkg::sample_t                   prev_ax;
    tst_pkg::diff_t                     d_ax;
    logic [tst_pkg::L1_BITS-1:0]        l1_s;
    logic [tst_pkg::L1_BITS-1:0]        l1_d;
    logic                               jerk_ops;
    logic                               need_mac;
    logic                               need_sqrt;
    logic                               has_main;
    tst_pkg::value_t                    simple_val;
    tst_pkg::diff_t                     mac_op;
    logic                               sqrt_done;
    logic [tst_pkg::ROOT_BITS-1:0]      root;
    tst_pkg::value_t                    main_val;

    function automatic logic [tst_pkg::DIFF_BITS-1:0] mag_of(input tst_pkg::diff_t v);
        logic [tst_pkg::DIFF_BITS-1:0] r;
        begin
            r = v[tst_pkg::DIFF_BITS-1] ? (~v + 1'b1) : v;
            return r;
        end
    endfunction

    function automatic tst_pkg::sample_t med3(input tst_pkg::sample_t a,
                                              input tst_pkg::sample_t b,
                                              input tst_pkg::sample_t c);
        tst_pkg::sample_t lo;
        tst_pkg::sample_t hi;
        tst_pkg::sample_t r;
        begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            if (c <= lo)
            begin
                r = lo;
            end
            else if (c >= hi)
            begin
                r = hi;
            end
            else
            begin
                r = c;
            end
            return r;
        end
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tst_pkg::MODE_JERK;
            axis_reg <= tst_pkg::AXIS_X;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tst_pkg::REG_MODE)
            begin
                mode_reg <= cfg_data[2:0];
            end
            else if (cfg_index == tst_pkg::REG_AXIS_SELECT)
            begin
                axis_reg <= cfg_data[1:0];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_in[i] = s_tdata[i*tst_pkg::SAMPLE_BITS +: tst_pkg::SAMPLE_BITS];
            d_in[i] = tst_pkg::diff_t'(s_in[i]) - tst_pkg::diff_t'(prev_reg[i]);
        end

        // unused axis code falls back to z
        case (axis_reg)
            tst_pkg::AXIS_X: ax = tst_pkg::AXIS_X;
            tst_pkg::AXIS_Y: ax = tst_pkg::AXIS_Y;
            default:         ax = tst_pkg::AXIS_Z;
        endcase

        case (ax)
            tst_pkg::AXIS_X:
            begin
                cur_ax  = s_in[0];
                prev_ax = prev_reg[0];
                d_ax    = d_in[0];
            end
            tst_pkg::AXIS_Y:
            begin
                cur_ax  = s_in[1];
                prev_ax = prev_reg[1];
                d_ax    = d_in[1];
            end
            default:
            begin
                cur_ax  = s_in[2];
                prev_ax = prev_reg[2];
                d_ax    = d_in[2];
            end
        endcase

        l1_s = tst_pkg::L1_BITS'(mag_of(tst_pkg::diff_t'(s_in[0])))
             + tst_pkg::L1_BITS'(mag_of(tst_pkg::diff_t'(s_in[1])))
             + tst_pkg::L1_BITS'(mag_of(tst_pkg::diff_t'(s_in[2])));
        l1_d = tst_pkg::L1_BITS'(mag_of(d_in[0]))
             + tst_pkg::L1_BITS'(mag_of(d_in[1]))
             + tst_pkg::L1_BITS'(mag_of(d_in[2]));

        jerk_ops   = 1'b0;
        need_mac   = 1'b0;
        need_sqrt  = 1'b0;
        has_main   = 1'b1;
        simple_val = '0;
        case (mode_reg)
            tst_pkg::MODE_JERK:
            begin
                has_main   = (seen_reg != 2'd0);
                simple_val = tst_pkg::value_t'(d_ax);
            end
            tst_pkg::MODE_MAGSQ:
            begin
                need_mac = 1'b1;
            end
            tst_pkg::MODE_MAG:
            begin
                need_mac  = 1'b1;
                need_sqrt = 1'b1;
            end
            tst_pkg::MODE_L1:
            begin
                simple_val = tst_pkg::value_t'(l1_s);
            end
            tst_pkg::MODE_JERK_MAGSQ:
            begin
                jerk_ops = 1'b1;
                has_main = (seen_reg != 2'd0);
                need_mac = has_main;
            end
            tst_pkg::MODE_JERK_MAG:
            begin
                jerk_ops  = 1'b1;
                has_main  = (seen_reg != 2'd0);
                need_mac  = has_main;
                need_sqrt = has_main;
            end
            tst_pkg::MODE_JERK_L1:
            begin
                has_main   = (seen_reg != 2'd0);
                simple_val = tst_pkg::value_t'(l1_d);
            end
            default:
            begin
                // median: zero on the first sample, nothing on the second
                has_main = (seen_reg != 2'd1);
                if (seen_reg != 2'd0)
                begin
                    simple_val = tst_pkg::value_t'(med3(older_reg, prev_ax, cur_ax));
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prev_reg[i] <= '0;
            end
            older_reg     <= '0;
            seen_reg      <= 2'd0;
            need_mac_reg  <= 1'b0;
            need_sqrt_reg <= 1'b0;
            has_main_reg  <= 1'b0;
            final_reg     <= 1'b0;
        end
        else if (cmd.accept)
        begin
            older_reg <= prev_ax;
            for (int i = 0; i < 3; i++)
            begin
                prev_reg[i] <= s_in[i];
            end
            if (s_tlast)
            begin
                seen_reg <= 2'd0;
            end
            else if (seen_reg != 2'd2)
            begin
                seen_reg <= seen_reg + 2'd1;
            end
            need_mac_reg  <= need_mac;
            need_sqrt_reg <= need_sqrt;
            has_main_reg  <= has_main;
            final_reg     <= s_tlast;
        end
    end

    always_comb
    begin
        case (cmd.mac_idx)
            2'd0:    mac_op = op_reg[0];
            2'd1:    mac_op = op_reg[1];
            default: mac_op = op_reg[2];
        endcase
    end

    // square one operand per step, then fold the registered product into the sum
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg   <= mode_reg;
            simple_reg <= simple_val;
            acc_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                op_reg[i] <= jerk_ops ? d_in[i] : tst_pkg::diff_t'(s_in[i]);
            end
        end
        else if (cmd.mac_step)
        begin
            prod_reg <= mac_op * mac_op;
            if (cmd.mac_idx != 2'd0)
            begin
                acc_reg <= acc_reg + tst_pkg::ACC_BITS'(unsigned'(prod_reg));
            end
        end
    end

    tst_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand ({acc_reg, {tst_pkg::FRAC_SHIFT{1'b0}}}),
        .done     (sqrt_done),
        .root     (root)
    );

    always_comb
    begin
        case (kind_reg)
            tst_pkg::MODE_MAG,
            tst_pkg::MODE_JERK_MAG:   main_val = tst_pkg::value_t'(root);
            tst_pkg::MODE_MAGSQ,
            tst_pkg::MODE_JERK_MAGSQ: main_val = tst_pkg::value_t'(acc_reg);
            default:                  main_val = simple_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_main || cmd.load_last)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_main)
        begin
            m_value_reg <= main_val;
            m_last_reg  <= 1'b0;
        end
        else if (cmd.load_last)
        begin
            m_value_reg <= '0;
            m_last_reg  <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = tst_pkg::OUT_TDATA_BITS'(unsigned'(m_value_reg));
    assign m_tlast  = m_last_reg;

    always_comb
    begin
        status.need_mac  = need_mac_reg;
        status.need_sqrt = need_sqrt_reg;
        status.has_main  = has_main_reg;
        status.is_final  = final_reg;
        status.sqrt_done = sqrt_done;
        status.out_free  = !m_tvalid_reg || m_tready;
    end

endmodule
`default_nettype wire

@@ hw/rtl/tst_ctrl.sv @@
// Controller: sequences accept, multiply steps, root and result hand-off.
`default_nettype none
module tst_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire tst_pkg::status_t    status,
    output tst_pkg::cmd_t            cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CHECK   = 3'd1;
    localparam logic [2:0] ST_MAC     = 3'd2;
    localparam logic [2:0] ST_SQ_GO   = 3'd3;
    localparam logic [2:0] ST_SQRT    = 3'd4;
    localparam logic [2:0] ST_EMIT    = 3'd5;
    localparam logic [2:0] ST_LAST    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        s_tready       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.mac_step   = 1'b0;
        cmd.mac_idx    = idx_reg;
        cmd.sqrt_start = 1'b0;
        cmd.load_main  = 1'b0;
        cmd.load_last  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                idx_next = 2'd0;
                if (status.need_mac)
                begin
                    state_next = ST_MAC;
                end
                else if (status.has_main)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.is_final)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAC:
            begin
                // three squares plus a final step to fold the last product
                cmd.mac_step = 1'b1;
                idx_next     = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = status.need_sqrt ? ST_SQ_GO : ST_EMIT;
                end
            end
            ST_SQ_GO:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (status.sqrt_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_main = 1'b1;
                    state_next    = status.is_final ? ST_LAST : ST_IDLE;
                end
            end
            ST_LAST:
            begin
                if (status.out_free)
                begin
                    cmd.load_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/triaxial_sample_transform.sv @@
// Top level of the triaxial sample transform: controller plus datapath.
//
//  channel  dir  handshake              payload
//  cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data (0 mode, 1 axis_select)
//  s        in   s_tvalid/s_tready      s_tdata {z,y,x}, s_tlast final_sample
//  m        out  m_tvalid/m_tready      m_tdata value, m_tlast last_result
//
// One sample at a time. Accept, a decode state, then: jerk, l1 and median
// go straight to the result; the squared norms take 4 multiply steps on one
// shared multiplier; the magnitudes take 4 multiply steps, a start state and
// the 25-iteration root unit. A final sample adds a trailing result, loaded
// from its own state after the main result, if any.
// The output register holds a result while the next sample is accepted;
// a stalled output stops the block only at its next hand-off.
// Reset clears config, history and control; no clearing pass.
`default_nettype none
module triaxial_sample_transform (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tst_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [tst_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [tst_pkg::IN_TDATA_BITS-1:0]     s_tdata,  // sample_x, sample_y, sample_z
    input  wire logic                                  s_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [tst_pkg::OUT_TDATA_BITS-1:0]         m_tdata,  // value, zero pad
    output logic                                       m_tlast
);

    tst_pkg::cmd_t    cmd;
    tst_pkg::status_t status;

    tst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tst_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire
